@@ hdl/mlb_pkg.sv @@
// shared types and constants for the mac learning bridge
`default_nettype none

package mlb_pkg;

  localparam int MAC_W           = 48;
  localparam int PORT_W          = 4;
  localparam int DEF_TABLE_DEPTH = 64;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // one classified frame header as it waits in the queue
  typedef struct packed {
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] ingress;
    logic              bcast;
    logic              self;
  } item_t;

  typedef enum logic [1:0] {
    ACT_FORWARD       = 2'd0,
    ACT_FLOOD_BCAST   = 2'd1,
    ACT_FLOOD_UNKNOWN = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_AGE
  } eng_state_t;

endpackage

`default_nettype wire

@@ hdl/mlb_front.sv @@
// front end: takes frame headers, classifies them and queues them for the table engine
`default_nettype none

module mlb_front
  import mlb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MAC_W-1:0]  source_address,
  input  wire logic [MAC_W-1:0]  destination_address,
  input  wire logic [PORT_W-1:0] ingress_port,
  output logic                   busy,
  input  wire logic              pop,
  output logic                   avail,
  output item_t                  item
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  item_t       incoming;

  // classify the header on the way in
  always_comb begin
    incoming.src     = source_address;
    incoming.dst     = destination_address;
    incoming.ingress = ingress_port;
    incoming.bcast   = (destination_address == MAC_BCAST);
    incoming.self    = (destination_address == source_address);
  end

  assign busy  = (fill == 2'd2);
  assign push  = start && !busy;
  assign avail = (fill != 2'd0);
  assign item  = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/mlb_back.sv @@
// back end: table engine that learns the source, looks up the destination and ages entries
`default_nettype none

module mlb_back
  import mlb_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        avail,
  input  wire item_t       item,
  output logic             pop,
  output logic             done,
  output logic [1:0]       action,
  output logic [PORT_W-1:0] port_number
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = MAC_W + PORT_W;
  localparam logic [IW-1:0] LAST_RANK = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  // table memories: address and port per slot, age rank per slot (0 newest)
  logic [EW-1:0] ent_mem  [TABLE_DEPTH];
  logic [IW-1:0] rank_mem [TABLE_DEPTH];

  eng_state_t state, state_next;

  item_t          cur;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx;
  logic           rd_vld;
  logic [IW-1:0]  rd_slot;
  logic [EW-1:0]  ent_rd;
  logic [IW-1:0]  rank_rd;

  logic           src_found;
  logic [IW-1:0]  src_slot;
  logic [IW-1:0]  src_rank;
  logic           dst_found;
  logic [PORT_W-1:0] dst_port;
  logic [IW-1:0]  dst_rank;
  logic [IW-1:0]  old_slot;
  logic [IW-1:0]  tgt_slot;
  logic [IW-1:0]  tgt_rank;

  logic           issue;
  logic           resolve;
  logic [IW-1:0]  rd_addr;
  logic [CW-1:0]  cnt_m1;
  logic [MAC_W-1:0]  e_addr;
  logic [PORT_W-1:0] e_port;
  logic           full;
  logic           evict;
  logic           hit;
  logic [IW-1:0]  tslot;
  logic [IW-1:0]  trank;
  action_t        act_c;
  logic [PORT_W-1:0] port_c;
  logic           rank_we;
  logic [IW-1:0]  rank_wdata;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencing controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    resolve    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (avail) begin
          pop        = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = (idx < count);
        if (!issue) state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        resolve    = 1'b1;
        state_next = ST_AGE;
      end
      ST_AGE: begin
        issue = (idx < count);
        if (!issue) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign rd_addr = idx[IW-1:0];
  assign cnt_m1  = count - CW'(1);
  assign e_addr  = ent_rd[EW-1:PORT_W];
  assign e_port  = ent_rd[PORT_W-1:0];

  // slot chosen for the learned source and the decision on the destination
  always_comb begin
    full  = (count == DEPTH_CNT);
    evict = !src_found && full;
    if (src_found) begin
      tslot = src_slot;
      trank = src_rank;
    end else if (full) begin
      tslot = old_slot;
      trank = LAST_RANK;
    end else begin
      tslot = count[IW-1:0];
      trank = count[IW-1:0];
    end
    hit = dst_found && !(evict && dst_rank == LAST_RANK);
    if (cur.bcast) begin
      act_c  = ACT_FLOOD_BCAST;
      port_c = cur.ingress;
    end else if (cur.self) begin
      act_c  = ACT_FORWARD;
      port_c = cur.ingress;
    end else if (hit) begin
      act_c  = ACT_FORWARD;
      port_c = dst_port;
    end else begin
      act_c  = ACT_FLOOD_UNKNOWN;
      port_c = cur.ingress;
    end
  end

  // rank update during the ageing pass
  assign rank_we    = (state == ST_AGE) && rd_vld;
  assign rank_wdata = (rd_slot == tgt_slot) ? '0 :
                      (rank_rd < tgt_rank) ? rank_rd + IW'(1) : rank_rd;

  // table memories
  always_ff @(posedge clk) begin
    if (resolve) begin
      ent_mem[tslot] <= {cur.src, cur.ingress};
    end
    if (issue) begin
      ent_rd  <= ent_mem[rd_addr];
      rank_rd <= rank_mem[rd_addr];
    end
    if (rank_we) begin
      rank_mem[rd_slot] <= rank_wdata;
    end
  end

  // scan results and working registers
  always_ff @(posedge clk) begin
    rd_slot <= rd_addr;
    if (pop) begin
      cur <= item;
    end
    if (state == ST_SCAN && rd_vld) begin
      if (e_addr == cur.src) begin
        src_slot <= rd_slot;
        src_rank <= rank_rd;
      end
      if (e_addr == cur.dst) begin
        dst_port <= e_port;
        dst_rank <= rank_rd;
      end
      if (rank_rd == cnt_m1[IW-1:0]) begin
        old_slot <= rd_slot;
      end
    end
    if (resolve) begin
      tgt_slot    <= tslot;
      tgt_rank    <= trank;
      action      <= act_c;
      port_number <= port_c;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      src_found <= 1'b0;
      dst_found <= 1'b0;
      done      <= 1'b0;
    end else begin
      rd_vld <= issue;
      done   <= resolve;
      if (pop || resolve) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + CW'(1);
      end
      if (pop) begin
        src_found <= 1'b0;
        dst_found <= 1'b0;
      end else if (state == ST_SCAN && rd_vld) begin
        if (e_addr == cur.src) src_found <= 1'b1;
        if (e_addr == cur.dst) dst_found <= 1'b1;
      end
      if (resolve && !src_found && !full) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mac_learning_bridge.sv @@
// An idle engine pops a header, scans the learned entries and then resolves; done is registered from that resolve.
// The table engine takes no new header until it is through with the last: its scan of the entry memory,
// one entry read at a time, is followed by a rank ageing pass over the same memory.
// Two headers can wait in the front queue; busy is high while it is full.
// Reset empties the table at once through the fill count; no clearing pass is run.
// The receiver cannot stall: done is high for one cycle per result.
`default_nettype none

module mac_learning_bridge
  import mlb_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MAC_W-1:0]  source_address,
  input  wire logic [MAC_W-1:0]  destination_address,
  input  wire logic [PORT_W-1:0] ingress_port,
  output logic                   done,
  output logic [1:0]             action,
  output logic [PORT_W-1:0]      port_number
);

  logic  pop;
  logic  avail;
  item_t item;

  // accept and classify
  mlb_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .source_address      (source_address),
    .destination_address (destination_address),
    .ingress_port        (ingress_port),
    .busy                (busy),
    .pop                 (pop),
    .avail               (avail),
    .item                (item)
  );

  // learn, look up and age
  mlb_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (avail),
    .item        (item),
    .pop         (pop),
    .done        (done),
    .action      (action),
    .port_number (port_number)
  );

endmodule

`default_nettype wire
